### hw/rtl/gclc_pkg.sv
// ----------------------------------------------------------------------------
// gclc_pkg
// Shared constants, controller states and command types for the grid cell
// cache.
// ----------------------------------------------------------------------------
package gclc_pkg;

  localparam int ENTRIES_DEF    = 40;
  localparam int CELL_SHIFT_DEF = 22;
  localparam int DATA_W         = 32;
  localparam int SLOT_W         = 6;
  localparam int HALF_W         = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_RESOLVE,
    S_UPDATE,
    S_FLUSH
  } gclc_state_t;

  typedef struct packed {
    logic load;
    logic match;
    logic resolve;
    logic update;
    logic flush;
  } gclc_cmd_t;

endpackage

### hw/rtl/gclc_if.sv
// ----------------------------------------------------------------------------
// gclc_in_if / gclc_out_if
// Valid/ready channels for lookup items and result items.
// ----------------------------------------------------------------------------
interface gclc_in_if
  import gclc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;
  logic signed [DATA_W-1:0] pos_z;
  logic        [DATA_W-1:0] world_time;

  modport source (output valid, action, pos_x, pos_y, pos_z, world_time, input ready);
  modport sink   (input valid, action, pos_x, pos_y, pos_z, world_time, output ready);
endinterface

interface gclc_out_if
  import gclc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic [DATA_W-1:0] cell_key;
  logic              evicted;
  logic [DATA_W-1:0] evicted_key;

  modport source (output valid, hit, slot, cell_key, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, slot, cell_key, evicted, evicted_key, output ready);
endinterface

### hw/rtl/gclc_ctrl.sv
// ----------------------------------------------------------------------------
// gclc_ctrl
// Sequencer: accept, compare, select, write back or flush.
// ----------------------------------------------------------------------------
module gclc_ctrl
  import gclc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_action,
  output logic      in_ready,
  input  logic      out_busy,
  output gclc_cmd_t cmd
);

  gclc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_action ? S_FLUSH : S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = S_RESOLVE;
      end
      S_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_nxt   = S_UPDATE;
      end
      S_UPDATE: begin
        // hold the write until the result register can take the item
        if (!out_busy) begin
          cmd.update = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (!out_busy) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/gclc_dp.sv
// ----------------------------------------------------------------------------
// gclc_dp
// Entry store, parallel key compare, slot select, recency update and the
// result register.
// ----------------------------------------------------------------------------
module gclc_dp
  import gclc_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int CELL_SHIFT = CELL_SHIFT_DEF
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  gclc_cmd_t                cmd,
  input  logic signed [DATA_W-1:0] in_pos_x,
  input  logic signed [DATA_W-1:0] in_pos_y,
  input  logic signed [DATA_W-1:0] in_pos_z,
  input  logic        [DATA_W-1:0] in_world_time,
  output logic                     out_busy,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_hit,
  output logic        [SLOT_W-1:0] out_slot,
  output logic        [DATA_W-1:0] out_cell_key,
  output logic                     out_evicted,
  output logic        [DATA_W-1:0] out_evicted_key
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // latched item
  logic [DATA_W-1:0] key_r;
  logic [DATA_W-1:0] pos_x_r, pos_y_r, pos_z_r, time_r;

  // entry store: keys and ranks are compared in place, the rest is write-only
  logic [ENTRIES-1:0] valid_r;
  logic [DATA_W-1:0]  key_st_r  [ENTRIES];
  logic [IDX_W-1:0]   rank_r    [ENTRIES];
  logic [CNT_W-1:0]   count_r;
  logic [DATA_W-1:0]  time_mem  [ENTRIES];
  logic [DATA_W-1:0]  pos_x_mem [ENTRIES];
  logic [DATA_W-1:0]  pos_y_mem [ENTRIES];
  logic [DATA_W-1:0]  pos_z_mem [ENTRIES];

  // compare stage
  logic [ENTRIES-1:0] match_v_r, free_v_r, lru_v_r;
  logic [ENTRIES-1:0] match_v_nxt, lru_v_nxt;

  // select stage
  logic [ENTRIES-1:0] sel_oh_r, sel_oh_nxt;
  logic [IDX_W-1:0]   slot_r, slot_nxt;
  logic [IDX_W-1:0]   hit_rank_r, hit_rank_nxt;
  logic               hit_r, hit_nxt;
  logic               evict_r, evict_nxt;
  logic [DATA_W-1:0]  ev_key_r, ev_key_nxt;

  // result register
  logic               out_valid_r;
  logic               out_hit_r, out_evicted_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [DATA_W-1:0]  out_key_r, out_ev_key_r;

  logic signed [DATA_W-1:0] cell_x, cell_y;
  logic [DATA_W-1:0]        key_nxt;
  logic [ENTRIES-1:0]       match_oh, free_oh;
  logic                     full;

  // arithmetic shift, keep the low half of each cell coordinate
  always_comb begin
    cell_x  = in_pos_x >>> CELL_SHIFT;
    cell_y  = in_pos_y >>> CELL_SHIFT;
    key_nxt = {cell_y[HALF_W-1:0], cell_x[HALF_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r   <= key_nxt;
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      pos_z_r <= in_pos_z;
      time_r  <= in_world_time;
    end
  end

  // parallel compare against every stored key
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_v_nxt[i] = valid_r[i] && (key_st_r[i] == key_r);
      lru_v_nxt[i]   = valid_r[i] && (rank_r[i] == IDX_W'(ENTRIES - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      match_v_r <= match_v_nxt;
      free_v_r  <= ~valid_r;
      lru_v_r   <= lru_v_nxt;
    end
  end

  // lowest set bit isolation, then one-hot to index
  always_comb begin
    match_oh     = match_v_r & (~match_v_r + ENTRIES'(1));
    free_oh      = free_v_r & (~free_v_r + ENTRIES'(1));
    full         = (count_r == CNT_W'(ENTRIES));
    hit_nxt      = |match_v_r;
    evict_nxt    = !hit_nxt && full;
    if (hit_nxt) begin
      sel_oh_nxt = match_oh;
    end else if (full) begin
      sel_oh_nxt = lru_v_r;
    end else begin
      sel_oh_nxt = free_oh;
    end
    slot_nxt     = '0;
    hit_rank_nxt = '0;
    ev_key_nxt   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (sel_oh_nxt[i]) begin
        slot_nxt = slot_nxt | IDX_W'(i);
      end
      if (match_oh[i]) begin
        hit_rank_nxt = hit_rank_nxt | rank_r[i];
      end
      if (evict_nxt && lru_v_r[i]) begin
        ev_key_nxt = ev_key_nxt | key_st_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      sel_oh_r   <= sel_oh_nxt;
      slot_r     <= slot_nxt;
      hit_rank_r <= hit_rank_nxt;
      hit_r      <= hit_nxt;
      evict_r    <= evict_nxt;
      ev_key_r   <= ev_key_nxt;
    end
  end

  // recency update and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd.flush) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd.update) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (sel_oh_r[i]) begin
          rank_r[i]  <= '0;
          valid_r[i] <= 1'b1;
          if (!hit_r) begin
            key_st_r[i] <= key_r;
          end
        end else if (valid_r[i] && (!hit_r || (rank_r[i] < hit_rank_r))) begin
          rank_r[i] <= rank_r[i] + IDX_W'(1);
        end
      end
      if (!hit_r && !evict_r) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      time_mem[slot_r] <= time_r;
      if (!hit_r) begin
        pos_x_mem[slot_r] <= pos_x_r;
        pos_y_mem[slot_r] <= pos_y_r;
        pos_z_mem[slot_r] <= pos_z_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update || cmd.flush) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_hit_r     <= hit_r;
      out_slot_r    <= SLOT_W'(slot_r);
      out_key_r     <= key_r;
      out_evicted_r <= evict_r;
      out_ev_key_r  <= ev_key_r;
    end else if (cmd.flush) begin
      out_hit_r     <= 1'b0;
      out_slot_r    <= '0;
      out_key_r     <= '0;
      out_evicted_r <= 1'b0;
      out_ev_key_r  <= '0;
    end
  end

  assign out_busy        = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_slot        = out_slot_r;
  assign out_cell_key    = out_key_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_ev_key_r;

endmodule

### hw/rtl/grid_cell_lru_cache.sv
// ----------------------------------------------------------------------------
// grid_cell_lru_cache
// Fully associative cell cache with least recently used replacement.
//
//   channel  dir  payload
//   in_ch    in   action, pos_x, pos_y, pos_z, world_time
//   out_ch   out  hit, slot, cell_key, evicted, evicted_key
//
// a lookup steps through accept, key compare against all entries,
// slot select and write back; a flush through accept and clear
// the next item is accepted in the cycle after the write back
// valid bits and the fill count clear at reset, no clearing pass
// a stalled result holds in the output register; the write back of the
// following item waits until that register is free
// ----------------------------------------------------------------------------
module grid_cell_lru_cache
  import gclc_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int CELL_SHIFT = CELL_SHIFT_DEF
)
(
  input logic       clk,
  input logic       rst_n,
  gclc_in_if.sink   in_ch,
  gclc_out_if.source out_ch
);

  gclc_cmd_t cmd;
  logic      out_busy;
  logic      in_ready;

  gclc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ready),
    .out_busy  (out_busy),
    .cmd       (cmd)
  );

  assign in_ch.ready = in_ready;

  gclc_dp #(
    .ENTRIES    (ENTRIES),
    .CELL_SHIFT (CELL_SHIFT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_pos_x        (in_ch.pos_x),
    .in_pos_y        (in_ch.pos_y),
    .in_pos_z        (in_ch.pos_z),
    .in_world_time   (in_ch.world_time),
    .out_busy        (out_busy),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_hit         (out_ch.hit),
    .out_slot        (out_ch.slot),
    .out_cell_key    (out_ch.cell_key),
    .out_evicted     (out_ch.evicted),
    .out_evicted_key (out_ch.evicted_key)
  );

endmodule

### tb/sv/grid_cell_lru_cache_tb.sv
// ----------------------------------------------------------------------------
// grid_cell_lru_cache_tb
// Self-checking bench for the grid cell cache. Lookups and flushes go in
// through a queue-fed driver. A transaction-level cache predictor keeps its own
// keys, valid bits and recency ranks and produces the expected result for
// every accepted item. A monitor compares each result item field by field.
// ----------------------------------------------------------------------------
module grid_cell_lru_cache_tb
  import gclc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  N_ENT       = ENTRIES_DEF;
  localparam int  SHIFT       = CELL_SHIFT_DEF;
  localparam int  CYCLE_LIMIT = 400000;
  localparam int  N_RANDOM    = 1400;
  localparam int  MAX_REPORTS = 10;
  localparam bit  ACT_LOOKUP  = 1'b0;
  localparam bit  ACT_FLUSH   = 1'b1;

  typedef struct packed {
    logic              action;
    logic [DATA_W-1:0] pos_x;
    logic [DATA_W-1:0] pos_y;
    logic [DATA_W-1:0] pos_z;
    logic [DATA_W-1:0] world_time;
  } lookup_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] cell_key;
    logic              evicted;
    logic [DATA_W-1:0] evicted_key;
  } lookup_res_t;

  logic clk = 1'b0;
  logic rst_n;

  gclc_in_if  in_ch ();
  gclc_out_if out_ch ();

  grid_cell_lru_cache dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // cache image kept by the bench
  bit          cell_valid [N_ENT];
  logic [31:0] cell_key_mem [N_ENT];
  int unsigned cell_rank [N_ENT];
  int unsigned cell_count;

  lookup_t     pending [$];
  lookup_res_t expected_res [$];
  lookup_t     nxt;
  int          n_total;
  int          n_acc;
  int          n_res;
  int          n_fail;
  int          cycles;
  bit          in_took;

  logic [9:0]  pool_x [80];
  logic [9:0]  pool_y [80];

  function automatic logic [31:0] cell_of(input logic [31:0] pos_x, input logic [31:0] pos_y);
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    sx = pos_x;
    sy = pos_y;
    cx = sx >>> SHIFT;
    cy = sy >>> SHIFT;
    return {cy[15:0], cx[15:0]};
  endfunction

  function automatic lookup_res_t cache_access(input lookup_t it);
    lookup_res_t r;
    int          s;
    int unsigned worst;
    int unsigned limit;
    r = '0;
    s = -1;
    if (it.action == ACT_FLUSH) begin
      foreach (cell_valid[i]) cell_valid[i] = 1'b0;
      cell_count = 0;
      return r;
    end
    r.cell_key = cell_of(it.pos_x, it.pos_y);
    for (int i = 0; i < N_ENT; i++) begin
      if (s < 0 && cell_valid[i] && cell_key_mem[i] == r.cell_key) s = i;
    end
    if (s >= 0) begin
      r.hit = 1'b1;
      limit = cell_rank[s];
      for (int i = 0; i < N_ENT; i++) begin
        if (cell_valid[i] && cell_rank[i] < limit) cell_rank[i]++;
      end
      cell_rank[s] = 0;
    end else begin
      if (cell_count >= N_ENT) begin
        worst = 0;
        for (int i = 0; i < N_ENT; i++) begin
          if (cell_valid[i] && cell_rank[i] >= worst) begin
            worst = cell_rank[i];
            s = i;
          end
        end
        r.evicted = 1'b1;
        r.evicted_key = cell_key_mem[s];
        cell_valid[s] = 1'b0;
        cell_count--;
      end else begin
        for (int i = N_ENT - 1; i >= 0; i--) begin
          if (!cell_valid[i]) s = i;
        end
      end
      for (int i = 0; i < N_ENT; i++) begin
        if (cell_valid[i]) cell_rank[i]++;
      end
      cell_valid[s] = 1'b1;
      cell_key_mem[s] = r.cell_key;
      cell_rank[s] = 0;
      cell_count++;
    end
    r.slot = s[SLOT_W-1:0];
    return r;
  endfunction

  // three idle phases spread over the run, by item count
  function automatic int phase_of(input int n);
    if (n_total == 0) return 0;
    return (n * 3) / n_total;
  endfunction

  function automatic int send_idle_pct(input int n);
    case (phase_of(n))
      0: return 38;
      1: return 79;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct(input int n);
    case (phase_of(n))
      0: return 79;
      1: return 38;
      default: return 0;
    endcase
  endfunction

  task automatic add_item(input logic act, input logic [31:0] px, input logic [31:0] py,
                          input logic [31:0] pz, input logic [31:0] wt);
    lookup_t it;
    it.action = act;
    it.pos_x = px;
    it.pos_y = py;
    it.pos_z = pz;
    it.world_time = wt;
    pending.push_back(it);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct(n_acc)) begin
        nxt = pending.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.action <= nxt.action;
        in_ch.pos_x <= nxt.pos_x;
        in_ch.pos_y <= nxt.pos_y;
        in_ch.pos_z <= nxt.pos_z;
        in_ch.world_time <= nxt.world_time;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    in_took = rst_n && in_ch.valid && in_ch.ready;
    if (in_took) begin
      nxt.action = in_ch.action;
      nxt.pos_x = in_ch.pos_x;
      nxt.pos_y = in_ch.pos_y;
      nxt.pos_z = in_ch.pos_z;
      nxt.world_time = in_ch.world_time;
      expected_res.push_back(cache_access(nxt));
      n_acc++;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("grid_cell_lru_cache_tb: FAIL");
      $finish;
    end
  end

  // result monitor
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct(n_res));
  end

  always @(posedge clk) begin
    lookup_res_t want;
    lookup_res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.hit = out_ch.hit;
      got.slot = out_ch.slot;
      got.cell_key = out_ch.cell_key;
      got.evicted = out_ch.evicted;
      got.evicted_key = out_ch.evicted_key;
      n_res++;
      if (expected_res.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS) $display("result item %0d with nothing expected: %p", n_res, got);
      end else begin
        want = expected_res.pop_front();
        if (got.hit !== want.hit || got.slot !== want.slot || got.cell_key !== want.cell_key ||
            got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS) begin
            $display("result item %0d mismatch", n_res);
            $display("  hit exp %0b got %0b, slot exp %0d got %0d", want.hit, got.hit,
                     want.slot, got.slot);
            $display("  cell_key exp %h got %h", want.cell_key, got.cell_key);
            $display("  evicted exp %0b got %0b, evicted_key exp %h got %h", want.evicted,
                     got.evicted, want.evicted_key, got.evicted_key);
          end
        end
      end
    end
  end

  initial begin
    int          pool_n;
    int          roll;
    int          k;
    logic [31:0] px;
    logic [31:0] py;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_LOOKUP;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.world_time = '0;
    out_ch.ready = 1'b0;
    foreach (cell_valid[i]) cell_valid[i] = 1'b0;
    cell_count = 0;

    // directed: empty flush, extremes, hits across cell borders, refill after flush
    add_item(ACT_FLUSH, 32'h0, 32'h0, 32'h0, 32'h0);
    add_item(ACT_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0);
    add_item(ACT_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0);
    add_item(ACT_LOOKUP, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff);
    add_item(ACT_LOOKUP, 32'h80000000, 32'h80000000, 32'h80000000, 32'h0);
    add_item(ACT_LOOKUP, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h12345678);
    add_item(ACT_LOOKUP, 32'h003fffff, 32'h003fffff, 32'h1, 32'h1);
    add_item(ACT_LOOKUP, 32'h00400000, 32'h0, 32'h2, 32'h2);
    add_item(ACT_LOOKUP, 32'hffc00000, 32'h0, 32'h3, 32'h3);
    add_item(ACT_LOOKUP, 32'h0, 32'hffc00000, 32'h4, 32'h4);
    add_item(ACT_LOOKUP, 32'h7fc00000, 32'h80000000, 32'h5, 32'h5);
    add_item(ACT_LOOKUP, 32'h7fffffff, 32'h7fffffff, 32'h0, 32'h6);
    add_item(ACT_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h7);
    add_item(ACT_LOOKUP, 32'h80000000, 32'h80000000, 32'h0, 32'h8);
    add_item(ACT_FLUSH, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    add_item(ACT_LOOKUP, 32'hffffffff, 32'hffffffff, 32'h0, 32'h9);
    add_item(ACT_LOOKUP, 32'h0, 32'h0, 32'h0, 32'ha);
    add_item(ACT_FLUSH, 32'h0, 32'h0, 32'h0, 32'h0);
    add_item(ACT_FLUSH, 32'h0, 32'h0, 32'h0, 32'h0);
    add_item(ACT_LOOKUP, 32'h00400000, 32'h00400000, 32'h0, 32'hb);

    // random: mostly cells from a small working set so hits and evictions both happen
    pool_n = 1;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) begin
        pool_n = $urandom_range(20, 75);
        for (int i = 0; i < 80; i++) begin
          roll = $urandom_range(0, 99);
          pool_x[i] = (roll < 5) ? 10'h200 : (roll < 10) ? 10'h1ff : 10'($urandom_range(0, 1023));
          roll = $urandom_range(0, 99);
          pool_y[i] = (roll < 5) ? 10'h200 : (roll < 10) ? 10'h1ff : 10'($urandom_range(0, 1023));
        end
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        add_item(ACT_FLUSH, $urandom(), $urandom(), $urandom(), $urandom());
      end else if (roll < 10) begin
        add_item(ACT_LOOKUP, $urandom(), $urandom(), $urandom(), $urandom());
      end else begin
        k = $urandom_range(0, pool_n - 1);
        px = $urandom();
        py = $urandom();
        px[31:22] = pool_x[k];
        py[31:22] = pool_y[k];
        add_item(ACT_LOOKUP, px, py, $urandom(), $urandom());
      end
    end
    n_total = pending.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (n_acc == n_total);
    wait (expected_res.size() == 0);
    repeat (12) @(posedge clk);
    if (n_fail == 0) begin
      $display("grid_cell_lru_cache_tb: PASS");
    end else begin
      $display("grid_cell_lru_cache_tb: FAIL");
    end
    $finish;
  end

endmodule

### grid_cell_lru_cache.f
hw/rtl/gclc_pkg.sv
hw/rtl/gclc_if.sv
hw/rtl/gclc_ctrl.sv
hw/rtl/gclc_dp.sv
hw/rtl/grid_cell_lru_cache.sv
tb/sv/grid_cell_lru_cache_tb.sv
